// ===== sv/usc_pkg.sv =====
package usc_pkg;

	// Result codes carried on scheme_kind.
	typedef enum logic [2:0] {
		KIND_RELATIVE = 3'd0,
		KIND_PRIVATE  = 3'd1,
		KIND_HTTP     = 3'd2,
		KIND_HTTPS    = 3'd3,
		KIND_OTHER    = 3'd4
	} kind_t;

	// Parser phase, one-hot.
	typedef enum logic [2:0] {
		PH_SKIP = 3'b001,
		PH_NAME = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam int unsigned FLAG_PRIV  = 0;
	localparam int unsigned FLAG_HTTP  = 1;
	localparam int unsigned FLAG_HTTPS = 2;

	localparam logic [POS_W-1:0] LEN_PRIV  = 4'd8;
	localparam logic [POS_W-1:0] LEN_HTTP  = 4'd4;
	localparam logic [POS_W-1:0] LEN_HTTPS = 4'd5;

	// Lower-case letters of the private scheme name.
	localparam logic [7:0] PRIV_NAME [8] = '{
		8'h70, 8'h6f, 8'h73, 8'h69, 8'h74, 8'h72, 8'h6f, 8'h6e
	};
	// Lower-case letters of "http"; "https" adds a final 's'.
	localparam logic [7:0] HTTP_NAME [4] = '{8'h68, 8'h74, 8'h74, 8'h70};
	localparam logic [7:0] CHAR_S     = 8'h73;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;

endpackage

// ===== sv/url_scheme_classifier.sv =====
// URL scheme classifier. A URL enters one byte per item on char_byte, with
// last_byte set on its final byte; exactly that final item produces one
// result on scheme_kind (0 relative, 1 private scheme, 2 http, 3 https,
// 4 other scheme) and the parser then starts over for the next URL. Leading
// whitespace is skipped, a scheme is a letter followed by letters, digits,
// '+', '-' or '.', closed by ':', and names are compared without regard to
// case. A zero byte ends the string and the bytes after it are ignored.
// The block takes one item per clock cycle while the input side is not
// stalled: each byte is captured in an input register and from there
// passes through a single small stage of compares and flag updates into
// the parser state and the result register. The input side stalls only
// while a result is waiting and not being taken and the staged byte is
// itself a final byte.
module url_scheme_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_byte,
	input  logic       last_byte,
	output logic       kind_valid,
	input  logic       kind_ready,
	output logic [2:0] scheme_kind
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state.
	usc_pkg::phase_t             phase_q;
	usc_pkg::kind_t              kind_q;
	logic [2:0]                  flags_q;
	logic [usc_pkg::POS_W-1:0]   pos_q;

	// Result register.
	logic           res_valid_q;
	usc_pkg::kind_t res_kind_q;

	// Next state computed from the staged byte.
	usc_pkg::phase_t           phase_d;
	usc_pkg::kind_t            kind_d;
	logic [2:0]                flags_d;
	logic [usc_pkg::POS_W-1:0] pos_d;

	logic       advance;
	logic       is_upper;
	logic       is_letter;
	logic       is_digit;
	logic       is_space;
	logic       is_later;
	logic [7:0] low;
	logic       hit_priv;
	logic       hit_http;
	logic       hit_https;
	logic       take_name;
	usc_pkg::kind_t colon_kind;

	// The staged byte moves on unless it would produce a result while the
	// result register is still full and not being taken.
	assign advance    = valid_s1 && (!last_s1 || !res_valid_q || kind_ready);
	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			byte_s1 <= char_byte;
			last_s1 <= last_byte;
		end
	end

	// Character classes of the staged byte.
	assign is_upper  = (byte_s1 >= 8'h41) && (byte_s1 <= 8'h5a);
	assign is_letter = is_upper || ((byte_s1 >= 8'h61) && (byte_s1 <= 8'h7a));
	assign is_digit  = (byte_s1 >= 8'h30) && (byte_s1 <= 8'h39);
	assign is_space  = (byte_s1 == 8'h20) || (byte_s1 == 8'h09) ||
	                   (byte_s1 == 8'h0d) || (byte_s1 == 8'h0a) ||
	                   (byte_s1 == 8'h0c) || (byte_s1 == 8'h0b);
	assign is_later  = is_letter || is_digit || (byte_s1 == usc_pkg::CHAR_PLUS) ||
	                   (byte_s1 == usc_pkg::CHAR_MINUS) ||
	                   (byte_s1 == usc_pkg::CHAR_DOT);
	assign low       = is_upper ? (byte_s1 | 8'h20) : byte_s1;

	// Does the byte match each known name at the current position?
	assign hit_priv  = (pos_q < usc_pkg::LEN_PRIV) &&
	                   (usc_pkg::PRIV_NAME[pos_q[2:0]] == low);
	assign hit_http  = (pos_q < usc_pkg::LEN_HTTP) &&
	                   (usc_pkg::HTTP_NAME[pos_q[1:0]] == low);
	assign hit_https = (pos_q < usc_pkg::LEN_HTTP) ?
	                   (usc_pkg::HTTP_NAME[pos_q[1:0]] == low) :
	                   ((pos_q == usc_pkg::LEN_HTTP) && (low == usc_pkg::CHAR_S));

	// Kind decided when the colon closes the scheme name.
	always_comb begin
		if (flags_q[usc_pkg::FLAG_PRIV] && (pos_q == usc_pkg::LEN_PRIV)) begin
			colon_kind = usc_pkg::KIND_PRIVATE;
		end else if (flags_q[usc_pkg::FLAG_HTTP] && (pos_q == usc_pkg::LEN_HTTP)) begin
			colon_kind = usc_pkg::KIND_HTTP;
		end else if (flags_q[usc_pkg::FLAG_HTTPS] && (pos_q == usc_pkg::LEN_HTTPS)) begin
			colon_kind = usc_pkg::KIND_HTTPS;
		end else begin
			colon_kind = usc_pkg::KIND_OTHER;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		take_name = 1'b0;
		case (phase_q)
			usc_pkg::PH_SKIP: begin
				if (is_letter) begin
					phase_d   = usc_pkg::PH_NAME;
					take_name = 1'b1;
				end else if (!is_space) begin
					// A zero byte or any other non-letter means no scheme.
					phase_d = usc_pkg::PH_DONE;
					kind_d  = usc_pkg::KIND_RELATIVE;
				end
			end
			usc_pkg::PH_NAME: begin
				if (byte_s1 == usc_pkg::CHAR_COLON) begin
					phase_d = usc_pkg::PH_DONE;
					kind_d  = colon_kind;
				end else if (is_later) begin
					take_name = 1'b1;
				end else begin
					phase_d = usc_pkg::PH_DONE;
					kind_d  = usc_pkg::KIND_RELATIVE;
				end
			end
			default: begin
				// Decided: the rest of the URL is ignored.
			end
		endcase

		flags_d = flags_q;
		pos_d   = pos_q;
		if (take_name) begin
			flags_d[usc_pkg::FLAG_PRIV]  = flags_q[usc_pkg::FLAG_PRIV]  && hit_priv;
			flags_d[usc_pkg::FLAG_HTTP]  = flags_q[usc_pkg::FLAG_HTTP]  && hit_http;
			flags_d[usc_pkg::FLAG_HTTPS] = flags_q[usc_pkg::FLAG_HTTPS] && hit_https;
			if (pos_q != usc_pkg::POS_MAX) begin
				pos_d = pos_q + 1'b1;
			end
		end
	end

	// Parser state; returns to its start values after each final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= usc_pkg::PH_SKIP;
			kind_q  <= usc_pkg::KIND_RELATIVE;
			flags_q <= 3'b111;
			pos_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= usc_pkg::PH_SKIP;
				kind_q  <= usc_pkg::KIND_RELATIVE;
				flags_q <= 3'b111;
				pos_q   <= '0;
			end else begin
				phase_q <= phase_d;
				kind_q  <= kind_d;
				flags_q <= flags_d;
				pos_q   <= pos_d;
			end
		end
	end

	// Result register: loaded by a final byte, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (kind_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_kind_q <= (phase_d == usc_pkg::PH_DONE) ? kind_d : usc_pkg::KIND_RELATIVE;
		end
	end

	assign kind_valid  = res_valid_q;
	assign scheme_kind = res_kind_q;

endmodule
